FILE: rtl/lmc_pkg.sv
// ----------------------------------------------------------------------------
// lmc_pkg
// Shared types, constants and byte map of the LED chase frame engine.
// ----------------------------------------------------------------------------
package lmc_pkg;

	// frame layout
	localparam int DATA_WORDS  = 16;
	localparam int FRAME_WORDS = 17;
	localparam int SLOTS       = 6;

	// latch lengths on the driver
	localparam logic [1:0] LATCH_DATA   = 2'd1;
	localparam logic [1:0] LATCH_GLOBAL = 2'd3;

	// configuration register indexes
	localparam logic [1:0] CFG_TAIL_LENGTH = 2'd0;
	localparam logic [1:0] CFG_COLOR_RED   = 2'd1;
	localparam logic [1:0] CFG_COLOR_GREEN = 2'd2;
	localparam logic [1:0] CFG_COLOR_BLUE  = 2'd3;

	// one frame request handed from front to back
	typedef struct packed {
		logic [2:0]  row;
		logic [23:0] color;
		logic [15:0] mask;
		logic        row_end;
	} frame_req_t;

	// store byte b lives in slot b / 3, component b % 3
	typedef struct packed {
		logic [2:0] slot;
		logic [1:0] comp;
	} byte_loc_t;

	function automatic byte_loc_t byte_loc(input logic [3:0] b);
		byte_loc_t loc;
		case (b)
			4'd0:    loc = '{slot: 3'd0, comp: 2'd0};
			4'd1:    loc = '{slot: 3'd0, comp: 2'd1};
			4'd2:    loc = '{slot: 3'd0, comp: 2'd2};
			4'd3:    loc = '{slot: 3'd1, comp: 2'd0};
			4'd4:    loc = '{slot: 3'd1, comp: 2'd1};
			4'd5:    loc = '{slot: 3'd1, comp: 2'd2};
			4'd6:    loc = '{slot: 3'd2, comp: 2'd0};
			4'd7:    loc = '{slot: 3'd2, comp: 2'd1};
			4'd8:    loc = '{slot: 3'd2, comp: 2'd2};
			4'd9:    loc = '{slot: 3'd3, comp: 2'd0};
			4'd10:   loc = '{slot: 3'd3, comp: 2'd1};
			4'd11:   loc = '{slot: 3'd3, comp: 2'd2};
			4'd12:   loc = '{slot: 3'd4, comp: 2'd0};
			4'd13:   loc = '{slot: 3'd4, comp: 2'd1};
			4'd14:   loc = '{slot: 3'd4, comp: 2'd2};
			4'd15:   loc = '{slot: 3'd5, comp: 2'd0};
			default: loc = '{slot: 3'd0, comp: 2'd0};
		endcase
		return loc;
	endfunction

endpackage

FILE: rtl/lmc_if.sv
// ----------------------------------------------------------------------------
// lmc channel interfaces
// Tick request channel and driver word channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface lmc_tick_if;
	logic valid;
	logic ready;
	logic tick;

	modport source (output valid, output tick, input ready);
	modport sink   (input valid, input tick, output ready);
endinterface

interface lmc_word_if;
	logic        valid;
	logic        ready;
	logic [15:0] gray_word;
	logic [1:0]  latch_clocks;
	logic [15:0] column_mask;
	logic        last;

	modport source (output valid, output gray_word, output latch_clocks,
		output column_mask, output last, input ready);
	modport sink   (input valid, input gray_word, input latch_clocks,
		input column_mask, input last, output ready);
endinterface

FILE: rtl/lmc_front.sv
// ----------------------------------------------------------------------------
// lmc_front
// Takes tick requests, drops idle ones, builds the column mask and advances
// the serpentine position; holds the configuration registers.
// ----------------------------------------------------------------------------
module lmc_front
	import lmc_pkg::*;
#(
	parameter int COLUMNS = 16,
	parameter int ROWS    = 6
) (
	input  logic        clk,
	input  logic        arst_n,
	lmc_tick_if.sink    tick_in,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	output logic        push_valid,
	input  logic        push_ready,
	output frame_req_t  push_req
);

	logic [4:0]  tail_q;
	logic [7:0]  red_q;
	logic [7:0]  green_q;
	logic [7:0]  blue_q;
	logic [4:0]  col_q;
	logic [2:0]  row_q;
	logic        rev_q;

	logic        accept;
	logic [15:0] fwd_mask;
	logic [15:0] rev_mask;
	logic [15:0] span;
	logic [4:0]  shamt;
	logic [4:0]  col_nxt;
	logic        row_end;

	assign tick_in.ready = push_ready;
	assign accept        = tick_in.valid && tick_in.ready;
	assign push_valid    = tick_in.valid && tick_in.tick;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tail_q  <= 5'd3;
			red_q   <= 8'd255;
			green_q <= 8'd0;
			blue_q  <= 8'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_TAIL_LENGTH: tail_q  <= cfg_data[4:0];
				CFG_COLOR_RED:   red_q   <= cfg_data;
				CFG_COLOR_GREEN: green_q <= cfg_data;
				CFG_COLOR_BLUE:  blue_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// forward mask: head alone near row start, else tail_q bits ending at head
	always_comb begin
		span  = 16'((17'(1) << tail_q) - 17'(1));
		shamt = 5'(col_q + 5'd1 - tail_q);
		if (col_q < tail_q) begin
			fwd_mask = 16'(1) << col_q[3:0];
		end else begin
			fwd_mask = span << shamt;
		end
	end

	// mirrored mask for the backward sweep
	always_comb begin
		rev_mask = '0;
		for (int c = 0; c < COLUMNS; c++) begin
			rev_mask[COLUMNS - 1 - c] = fwd_mask[c];
		end
	end

	assign col_nxt = col_q + 5'd1;
	assign row_end = (col_nxt == 5'(COLUMNS));

	always_comb begin
		push_req.row     = row_q;
		push_req.color   = {red_q, green_q, blue_q};
		push_req.mask    = rev_q ? rev_mask : fwd_mask;
		push_req.row_end = row_end;
	end

	// serpentine position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			rev_q <= 1'b0;
		end else if (accept && tick_in.tick) begin
			if (row_end) begin
				col_q <= '0;
				row_q <= (row_q == 3'(ROWS - 1)) ? 3'd0 : row_q + 3'd1;
				rev_q <= !rev_q;
			end else begin
				col_q <= col_nxt;
			end
		end
	end

endmodule

FILE: rtl/lmc_req_queue.sv
// ----------------------------------------------------------------------------
// lmc_req_queue
// Two-entry queue of frame requests between front and back.
// ----------------------------------------------------------------------------
module lmc_req_queue
	import lmc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push_valid,
	output logic        push_ready,
	input  frame_req_t  push_req,
	output logic        pop_valid,
	input  logic        pop_ready,
	output frame_req_t  pop_req
);

	frame_req_t  entry_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;
	logic        push;
	logic        pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_req    = entry_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_req;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop)  rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

FILE: rtl/lmc_back.sv
// ----------------------------------------------------------------------------
// lmc_back
// Holds the colour store and plays one frame request out as 17 driver words
// through an output register.
// ----------------------------------------------------------------------------
module lmc_back
	import lmc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  frame_req_t  req,
	lmc_word_if.source  word_out
);

	logic [23:0] store_q [SLOTS];
	logic [4:0]  word_cnt_q;
	logic        out_valid_q;
	logic [15:0] gray_q;
	logic [1:0]  latch_q;
	logic [15:0] mask_q;
	logic        last_q;

	logic        emit;
	logic        final_word;
	byte_loc_t   loc;
	logic [23:0] slot_word;
	logic [7:0]  byte_val;
	logic [15:0] gray_val;

	assign emit       = req_valid && (!out_valid_q || word_out.ready);
	assign final_word = (word_cnt_q == 5'(FRAME_WORDS - 1));
	assign req_ready  = emit && final_word;

	// store byte 15 - k, the head request's slot bypasses the store
	always_comb begin
		loc       = byte_loc(4'(DATA_WORDS - 1) - word_cnt_q[3:0]);
		slot_word = (loc.slot == req.row) ? req.color : store_q[loc.slot];
		case (loc.comp)
			2'd0:    byte_val = slot_word[23:16];
			2'd1:    byte_val = slot_word[15:8];
			2'd2:    byte_val = slot_word[7:0];
			default: byte_val = 8'd0;
		endcase
		// times 255
		gray_val = {byte_val, 8'd0} - {8'd0, byte_val};
	end

	// colour store: load at frame start, clear after the last frame of a row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < SLOTS; s++) store_q[s] <= '0;
		end else if (emit) begin
			if (word_cnt_q == 5'd0) begin
				store_q[req.row] <= req.color;
			end else if (final_word && req.row_end) begin
				store_q[req.row] <= '0;
			end
		end
	end

	// word counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_cnt_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				word_cnt_q <= final_word ? 5'd0 : word_cnt_q + 5'd1;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (word_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (emit) begin
			gray_q  <= final_word ? 16'd0 : gray_val;
			latch_q <= final_word ? LATCH_GLOBAL : LATCH_DATA;
			mask_q  <= req.mask;
			last_q  <= final_word;
		end
	end

	assign word_out.valid        = out_valid_q;
	assign word_out.gray_word    = gray_q;
	assign word_out.latch_clocks = latch_q;
	assign word_out.column_mask  = mask_q;
	assign word_out.last         = last_q;

	// counter never runs past the frame
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		word_cnt_q < 5'(FRAME_WORDS))
		else $error("word counter past frame end");

	// no request waiting means no frame half played
	a_idle_boundary: assert property (@(posedge clk) disable iff (!arst_n)
		!req_valid |-> word_cnt_q == 5'd0)
		else $error("frame interrupted without a request");

	// a frame is released only together with its global latch word
	a_release_last: assert property (@(posedge clk) disable iff (!arst_n)
		req_ready |=> out_valid_q && last_q && gray_q == 16'd0)
		else $error("request released without closing word");

endmodule

FILE: rtl/led_matrix_chase_frame_engine_top.sv
// ----------------------------------------------------------------------------
// led_matrix_chase_frame_engine_top
// Serpentine LED chase: each tick request with tick set yields one 17-word driver frame.
//
//   channel    dir   handshake      payload
//   tick_in    in    valid/ready    tick
//   word_out   out   valid/ready    gray_word, latch_clocks, column_mask, last
//   cfg        in    cfg_we         cfg_index, cfg_data
//
// A tick of 1 yields 17 words, one per cycle from the back end's output
// register unless stalled; a tick of 0 passes while the queue has room.
// The request queue holds two frames: the one playing out and one waiting.
// Reset clears position and color store and sets the configuration registers to their defaults at once.
// A stalled output holds the back end; the front keeps taking ticks
// until the queue is full.
// ----------------------------------------------------------------------------
module led_matrix_chase_frame_engine_top
	import lmc_pkg::*;
#(
	parameter int COLUMNS = 16,
	parameter int ROWS    = 6
) (
	input  logic        clk,
	input  logic        arst_n,
	lmc_tick_if.sink    tick_in,
	lmc_word_if.source  word_out,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	logic       push_valid;
	logic       push_ready;
	frame_req_t push_req;
	logic       pop_valid;
	logic       pop_ready;
	frame_req_t pop_req;

	// accept and classify
	lmc_front #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.tick_in    (tick_in),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_req   (push_req)
	);

	// frame request queue
	lmc_req_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_req   (push_req),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_req    (pop_req)
	);

	// frame playout
	lmc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (pop_valid),
		.req_ready (pop_ready),
		.req       (pop_req),
		.word_out  (word_out)
	);

endmodule
